[design/irc_tok_pkg.sv]
// shared types, constants and keyword tables of the irc command line tokenizer
`timescale 1ns / 1ps
`default_nettype none
package irc_tok_pkg;

    localparam int MAX_PARAMS_DEF = 15;
    localparam int HOLD_DEPTH_DEF = 32;

    localparam int NKEYS = 14;
    localparam logic [3:0] CODE_UNKNOWN = 4'd14;

    // request and result kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_EOL  = 1'b1;
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // line phases
    localparam logic [2:0] PH_LEAD        = 3'd0;
    localparam logic [2:0] PH_NAME        = 3'd1;
    localparam logic [2:0] PH_GAP         = 3'd2;
    localparam logic [2:0] PH_TOKEN       = 3'd3;
    localparam logic [2:0] PH_TRAIL_START = 3'd4;
    localparam logic [2:0] PH_TRAIL       = 3'd5;
    localparam logic [2:0] PH_DISCARD     = 3'd6;

    // held blank codes
    localparam logic [1:0] HC_SPACE = 2'd0;
    localparam logic [1:0] HC_TAB   = 2'd1;
    localparam logic [1:0] HC_CR    = 2'd2;
    localparam logic [1:0] HC_LF    = 2'd3;

    // keyword text, right-justified, first character in the highest used byte
    localparam logic [63:0] KW_TEXT [NKEYS] = '{
        "WHOIS", "BOT", "CAP", "PASS", "NICK", "USER", "PRIVMSG",
        "INVITE", "JOIN", "PART", "PING", "KICK", "MODE", "TOPIC"
    };
    localparam logic [3:0] KW_LEN [NKEYS] = '{
        4'd5, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd7,
        4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5
    };

    typedef struct packed {
        logic accept;      // input item taken this cycle
        logic emit_held;   // send the next held blank
        logic emit_saved;  // send the byte that closed the held run
    } ctrl_cmd_t;

    typedef struct packed {
        logic direct_result; // the offered item makes exactly one result at once
        logic start_flush;   // the offered item releases a held run
        logic flush_last;    // current held entry is the last one
    } dp_status_t;

    // character at position pos of keyword k, valid for pos below its length
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [2:0] sel;
        sel = 3'(KW_LEN[k] - 4'd1 - pos);
        return KW_TEXT[k][{sel, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] held_char(input logic [1:0] code);
        logic [7:0] c;
        case (code)
            HC_SPACE: c = 8'h20;
            HC_TAB:   c = 8'h09;
            HC_CR:    c = 8'h0D;
            HC_LF:    c = 8'h0A;
            default:  c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] held_code_of(input logic [7:0] b);
        logic [1:0] c;
        case (b)
            8'h09:   c = HC_TAB;
            8'h0D:   c = HC_CR;
            8'h0A:   c = HC_LF;
            default: c = HC_SPACE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[design/irc_tok_if.sv]
// valid/ready channels for line bytes in and tokenizer results out
`timescale 1ns / 1ps
`default_nettype none
interface irc_tok_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface irc_tok_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] param_byte;
    logic [3:0] param_index;
    logic       param_first;
    logic [3:0] cmd_code;
    logic [3:0] param_count;
    logic       overflow;
    logic       last;

    modport source (output valid, output out_kind, output param_byte, output param_index,
                    output param_first, output cmd_code, output param_count,
                    output overflow, output last, input ready);
    modport sink (input valid, input out_kind, input param_byte, input param_index,
                  input param_first, input cmd_code, input param_count,
                  input overflow, input last, output ready);
endinterface
`default_nettype wire

[design/irc_tok_ctrl.sv]
// controller: input handshake, held-run flush sequencing and output valid
`timescale 1ns / 1ps
`default_nettype none
module irc_tok_ctrl
    import irc_tok_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_LAST  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       load;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_RUN) && out_free;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.emit_held  = 1'b0;
        cmd.emit_saved = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                cmd.accept = in_valid && out_free;
                if (cmd.accept && status.start_flush)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                cmd.emit_held = out_free;
                if (out_free && status.flush_last)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                cmd.emit_saved = out_free;
                if (out_free)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
        load = (cmd.accept && status.direct_result) || cmd.emit_held || cmd.emit_saved;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[design/irc_tok_dp.sv]
// datapath: line state, keyword match, held blank memory and result register
`timescale 1ns / 1ps
`default_nettype none
module irc_tok_dp
    import irc_tok_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_type,
    input  wire logic [7:0] in_byte,
    input  wire ctrl_cmd_t  cmd,
    output dp_status_t      status,
    output logic            out_kind,
    output logic [7:0]      param_byte,
    output logic [3:0]      param_index,
    output logic            param_first,
    output logic [3:0]      cmd_code,
    output logic [3:0]      param_count,
    output logic            overflow,
    output logic            last
);

    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

    // line state
    logic [2:0]        phase_reg, phase_next;
    logic [NKEYS-1:0]  hits_reg, hits_next;
    logic [3:0]        nl_reg, nl_next;
    logic              tp_reg, tp_next;
    logic [3:0]        ps_reg, ps_next;
    logic [CNT_W-1:0]  hc_reg, hc_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;

    // payload registers
    logic [7:0]        saved_reg;
    logic              start_reg;
    logic [1:0]        rd_data_reg;
    logic [1:0]        held_mem [HOLD_DEPTH];

    logic              o_kind_reg, o_first_reg, o_ovf_reg, o_last_reg;
    logic [7:0]        o_byte_reg;
    logic [3:0]        o_idx_reg, o_code_reg, o_count_reg;

    // combinational
    logic              is_trim, is_cspace, is_lead_blank;
    logic [2:0]        ph_eff;
    logic [7:0]        up;
    logic [NKEYS-1:0]  hit_ok;
    logic [3:0]        code_now;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              dir_valid, dir_kind, dir_first;
    logic [7:0]        dir_byte;
    logic [3:0]        dir_idx;
    logic              flush_start;
    logic              load_dir;

    assign is_trim = (in_byte inside {8'h20, 8'h09, 8'h0D, 8'h0A});
    assign is_cspace = (in_byte inside {8'h20, [8'h09:8'h0D]});
    assign is_lead_blank = (in_byte inside {8'h20, 8'h09});
    assign up = (in_byte inside {[8'h61:8'h7A]}) ? in_byte - 8'h20 : in_byte;
    assign ph_eff = (phase_reg == PH_LEAD && !is_lead_blank) ? PH_NAME : phase_reg;

    always_comb
    begin
        for (int k = 0; k < NKEYS; k++)
            hit_ok[k] = hits_reg[k] && (nl_reg < KW_LEN[k]) && (kw_char(k, nl_reg) == up);
    end

    // lowest matching keyword wins
    always_comb
    begin
        code_now = CODE_UNKNOWN;
        for (int k = NKEYS - 1; k >= 0; k--)
            if (hits_reg[k] && KW_LEN[k] == nl_reg)
                code_now = 4'(k);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hits_next   = hits_reg;
        nl_next     = nl_reg;
        tp_next     = tp_reg;
        ps_next     = ps_reg;
        hc_next     = hc_reg;
        ovf_next    = ovf_reg;
        dir_valid   = 1'b0;
        dir_kind    = KIND_BYTE;
        dir_first   = 1'b0;
        dir_byte    = in_byte;
        dir_idx     = ps_reg - 4'd1;
        flush_start = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = hc_reg[IDX_W-1:0];

        if (req_type == REQ_EOL)
        begin
            dir_valid  = 1'b1;
            dir_kind   = KIND_SUMMARY;
            phase_next = PH_LEAD;
            hits_next  = '1;
            nl_next    = 4'd0;
            tp_next    = 1'b0;
            ps_next    = 4'd0;
            hc_next    = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            // a blank tail on the name followed by a real byte spoils the match
            if (ph_eff != PH_NAME && ph_eff != PH_LEAD && tp_reg && !is_trim)
            begin
                hits_next = '0;
                tp_next   = 1'b0;
            end
            case (ph_eff)
                PH_LEAD:
                begin
                end
                PH_NAME:
                begin
                    phase_next = PH_NAME;
                    if (in_byte == 8'h20)
                        phase_next = PH_GAP;
                    else if (is_trim)
                        tp_next = 1'b1;
                    else
                    begin
                        hits_next = tp_reg ? '0 : hit_ok;
                        tp_next   = 1'b0;
                        if (nl_reg != 4'd15)
                            nl_next = nl_reg + 4'd1;
                    end
                end
                PH_GAP:
                begin
                    if (!is_cspace)
                    begin
                        if (ps_reg >= 4'(MAX_PARAMS))
                        begin
                            ovf_next   = 1'b1;
                            phase_next = PH_DISCARD;
                        end
                        else if (in_byte == 8'h3A)
                        begin
                            ps_next    = ps_reg + 4'd1;
                            hc_next    = '0;
                            phase_next = PH_TRAIL_START;
                        end
                        else
                        begin
                            dir_valid  = 1'b1;
                            dir_first  = 1'b1;
                            dir_idx    = ps_reg;
                            ps_next    = ps_reg + 4'd1;
                            phase_next = PH_TOKEN;
                        end
                    end
                end
                PH_TOKEN:
                begin
                    if (is_cspace)
                        phase_next = PH_GAP;
                    else
                        dir_valid = 1'b1;
                end
                PH_TRAIL_START, PH_TRAIL:
                begin
                    if (is_trim)
                    begin
                        if (hc_reg < CNT_W'(HOLD_DEPTH))
                        begin
                            wr_en   = 1'b1;
                            hc_next = hc_reg + CNT_W'(1);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TRAIL;
                        if (hc_reg == '0)
                        begin
                            dir_valid = 1'b1;
                            dir_first = (ph_eff == PH_TRAIL_START);
                        end
                        else
                            flush_start = 1'b1;  // held count cleared when the byte goes out
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.direct_result = dir_valid;
    assign status.start_flush   = flush_start;
    assign status.flush_last    = (CNT_W'(fidx_reg) == hc_reg - CNT_W'(1));
    assign load_dir = cmd.accept && dir_valid;

    always_comb
    begin
        fidx_next = fidx_reg;
        if (cmd.accept)
            fidx_next = '0;
        else if (cmd.emit_held)
            fidx_next = status.flush_last ? '0 : fidx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            hits_reg  <= '1;
            nl_reg    <= 4'd0;
            tp_reg    <= 1'b0;
            ps_reg    <= 4'd0;
            hc_reg    <= '0;
            ovf_reg   <= 1'b0;
            fidx_reg  <= '0;
        end
        else
        begin
            fidx_reg <= fidx_next;
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                hits_reg  <= hits_next;
                nl_reg    <= nl_next;
                tp_reg    <= tp_next;
                ps_reg    <= ps_next;
                hc_reg    <= hc_next;
                ovf_reg   <= ovf_next;
            end
            else if (cmd.emit_saved)
                hc_reg <= '0;
        end
    end

    // held blank memory, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
            held_mem[wr_addr] <= held_code_of(in_byte);
        rd_data_reg <= held_mem[fidx_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && flush_start)
        begin
            saved_reg <= in_byte;
            start_reg <= (ph_eff == PH_TRAIL_START);
        end
        if (load_dir)
        begin
            o_kind_reg  <= dir_kind;
            o_byte_reg  <= (dir_kind == KIND_SUMMARY) ? 8'd0 : dir_byte;
            o_idx_reg   <= (dir_kind == KIND_SUMMARY) ? 4'd0 : dir_idx;
            o_first_reg <= dir_first;
            o_code_reg  <= (dir_kind == KIND_SUMMARY) ? code_now : 4'd0;
            o_count_reg <= (dir_kind == KIND_SUMMARY) ? ps_reg : 4'd0;
            o_ovf_reg   <= (dir_kind == KIND_SUMMARY) ? ovf_reg : 1'b0;
            o_last_reg  <= 1'b1;
        end
        else if (cmd.emit_held || cmd.emit_saved)
        begin
            o_kind_reg  <= KIND_BYTE;
            o_byte_reg  <= cmd.emit_held ? held_char(rd_data_reg) : saved_reg;
            o_idx_reg   <= ps_reg - 4'd1;
            o_first_reg <= cmd.emit_held && start_reg && (fidx_reg == '0);
            o_code_reg  <= 4'd0;
            o_count_reg <= 4'd0;
            o_ovf_reg   <= 1'b0;
            o_last_reg  <= cmd.emit_saved;
        end
    end

    assign out_kind    = o_kind_reg;
    assign param_byte  = o_byte_reg;
    assign param_index = o_idx_reg;
    assign param_first = o_first_reg;
    assign cmd_code    = o_code_reg;
    assign param_count = o_count_reg;
    assign overflow    = o_ovf_reg;
    assign last        = o_last_reg;

endmodule
`default_nettype wire

[design/irc_command_line_tokenizer_core.sv]
// top level of the irc command line tokenizer
//
//   channel  dir  payload                                          item
//   in_ch    in   req_type, in_byte                                one line byte or end of line
//   out_ch   out  out_kind, param_byte, param_index, param_first,  parameter byte or line summary
//                 cmd_code, param_count, overflow, last
//
// a byte or end-of-line item is taken when the output is free; one that closes a held blank
// run in a trailing parameter also makes the flush sequencer send every held blank, then the
// closing byte, reading held blanks one entry a cycle while the output does not stall.
// reset is asynchronous and active low and leaves the block at the start of an empty line.
// a stalled output holds the result register; input is taken once it frees and no flush runs.
`timescale 1ns / 1ps
`default_nettype none
module irc_command_line_tokenizer_core
    import irc_tok_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
)
(
    input wire logic     clk,
    input wire logic     rst_n,
    irc_tok_in_if.sink   in_ch,
    irc_tok_out_if.source out_ch
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // controller: handshakes and flush sequencing
    irc_tok_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: tokenizing state, keyword match, held run memory, result register
    irc_tok_dp #(
        .MAX_PARAMS (MAX_PARAMS),
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (in_ch.req_type),
        .in_byte     (in_ch.in_byte),
        .cmd         (cmd),
        .status      (status),
        .out_kind    (out_ch.out_kind),
        .param_byte  (out_ch.param_byte),
        .param_index (out_ch.param_index),
        .param_first (out_ch.param_first),
        .cmd_code    (out_ch.cmd_code),
        .param_count (out_ch.param_count),
        .overflow    (out_ch.overflow),
        .last        (out_ch.last)
    );

endmodule
`default_nettype wire

[tb/tb_irc_command_line_tokenizer_core.sv]
// self-checking testbench for the irc command line tokenizer core
`timescale 1ns / 1ps
module tb_irc_command_line_tokenizer_core;
    import irc_tok_pkg::*;

    // one result item as it leaves the block
    typedef struct packed {
        logic       kind;
        logic [7:0] pbyte;
        logic [3:0] pidx;
        logic       pfirst;
        logic [3:0] code;
        logic [3:0] count;
        logic       ovf;
        logic       last;
    } token_result_t;

    // line tokenizer prediction plus the queue of results still owed by the block
    class tokenizer_scoreboard;
        logic [2:0]    line_phase;
        logic [13:0]   kw_hits;
        logic [3:0]    name_len;
        bit            tail_pending;
        logic [3:0]    params_seen;
        logic [7:0]    held_run[$];
        bit            run_overflow;
        token_result_t owed_q[$];
        int            mismatches;
        string         kw_names[NKEYS];

        function new();
            kw_names = '{"WHOIS", "BOT", "CAP", "PASS", "NICK", "USER", "PRIVMSG",
                         "INVITE", "JOIN", "PART", "PING", "KICK", "MODE", "TOPIC"};
            mismatches = 0;
            clear_line();
        endfunction

        static function bit is_trim_blank(logic [7:0] b);
            return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
        endfunction

        static function bit is_sep(logic [7:0] b);
            return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        function void clear_line();
            line_phase   = PH_LEAD;
            kw_hits      = '1;
            name_len     = '0;
            tail_pending = 1'b0;
            params_seen  = '0;
            held_run.delete();
            run_overflow = 1'b0;
        endfunction

        function logic [3:0] command_of_line();
            for (int k = 0; k < NKEYS; k++)
                if (kw_hits[k] && kw_names[k].len() == name_len)
                    return 4'(k);
            return CODE_UNKNOWN;
        endfunction

        function token_result_t byte_result(logic [7:0] b, logic [3:0] idx, bit first);
            token_result_t r;
            r = '0;
            r.kind   = KIND_BYTE;
            r.pbyte  = b;
            r.pidx   = idx;
            r.pfirst = first;
            return r;
        endfunction

        function string show(token_result_t r);
            return $sformatf({"kind=%0d byte=%02h idx=%0d first=%0d ",
                              "code=%0d count=%0d ovf=%0d last=%0d"},
                             r.kind, r.pbyte, r.pidx, r.pfirst, r.code, r.count, r.ovf,
                             r.last);
        endfunction

        function void note_input(logic req, logic [7:0] b);
            token_result_t made[$];
            token_result_t r;
            logic [7:0]    up;
            bit            start;
            if (req == REQ_EOL)
            begin
                r = '0;
                r.kind  = KIND_SUMMARY;
                r.code  = command_of_line();
                r.count = params_seen;
                r.ovf   = run_overflow;
                r.last  = 1'b1;
                owed_q = {owed_q, r};
                clear_line();
                return;
            end
            if (line_phase == PH_LEAD)
            begin
                if (b == 8'h20 || b == 8'h09)
                    return;
                line_phase = PH_NAME;
            end
            if (line_phase == PH_NAME)
            begin
                if (b == 8'h20)
                    line_phase = PH_GAP;
                else if (b == 8'h09 || b == 8'h0D || b == 8'h0A)
                    tail_pending = 1'b1;
                else
                begin
                    if (tail_pending)
                    begin
                        kw_hits = '0;
                        tail_pending = 1'b0;
                    end
                    up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
                    for (int k = 0; k < NKEYS; k++)
                        if (name_len >= kw_names[k].len() || kw_names[k][name_len] != up)
                            kw_hits[k] = 1'b0;
                    if (name_len != 4'd15)
                        name_len++;
                end
                return;
            end
            if (tail_pending && !is_trim_blank(b))
            begin
                kw_hits = '0;
                tail_pending = 1'b0;
            end
            case (line_phase)
                PH_GAP:
                    if (!is_sep(b))
                    begin
                        if (params_seen >= MAX_PARAMS_DEF)
                        begin
                            run_overflow = 1'b1;
                            line_phase = PH_DISCARD;
                        end
                        else if (b == ":")
                        begin
                            params_seen++;
                            held_run.delete();
                            line_phase = PH_TRAIL_START;
                        end
                        else
                        begin
                            made = {made, byte_result(b, params_seen, 1'b1)};
                            params_seen++;
                            line_phase = PH_TOKEN;
                        end
                    end
                PH_TOKEN:
                    if (is_sep(b))
                        line_phase = PH_GAP;
                    else
                        made = {made, byte_result(b, params_seen - 4'd1, 1'b0)};
                PH_TRAIL_START, PH_TRAIL:
                    if (is_trim_blank(b))
                    begin
                        if (held_run.size() < HOLD_DEPTH_DEF)
                            held_run = {held_run, b};
                        else
                            run_overflow = 1'b1;
                    end
                    else
                    begin
                        start = (line_phase == PH_TRAIL_START);
                        foreach (held_run[i])
                            made = {made, byte_result(held_run[i], params_seen - 4'd1,
                                                      start && made.size() == 0)};
                        made = {made, byte_result(b, params_seen - 4'd1,
                                                  start && made.size() == 0)};
                        held_run.delete();
                        line_phase = PH_TRAIL;
                    end
                default: ;
            endcase
            if (made.size() > 0)
                made[made.size() - 1].last = 1'b1;
            foreach (made[i])
                owed_q = {owed_q, made[i]};
        endfunction

        function void check_result(token_result_t got);
            token_result_t want;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result, nothing owed: %s", show(got));
                return;
            end
            want = owed_q.pop_front();
            if (got.kind !== want.kind || got.pbyte !== want.pbyte || got.pidx !== want.pidx ||
                got.pfirst !== want.pfirst || got.code !== want.code ||
                got.count !== want.count || got.ovf !== want.ovf || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch\n  expected %s\n  actual   %s",
                             show(want), show(got));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    irc_tok_in_if  in_ch();
    irc_tok_out_if out_ch();

    irc_command_line_tokenizer_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    tokenizer_scoreboard sb;
    token_result_t       seen;

    logic [7:0] line_q[$];   // bytes of the line being built, end of line not included
    int         burst_left;  // items left in the current sender burst
    int         items_sent;
    int         ready_left;  // cycles left in the current receiver pattern
    int         ready_mode;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // safety net: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // monitor: note accepted items first, so a same-edge result still finds its expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.req_type, in_ch.in_byte);
            if (out_ch.valid && out_ch.ready)
            begin
                seen.kind   = out_ch.out_kind;
                seen.pbyte  = out_ch.param_byte;
                seen.pidx   = out_ch.param_index;
                seen.pfirst = out_ch.param_first;
                seen.code   = out_ch.cmd_code;
                seen.count  = out_ch.param_count;
                seen.ovf    = out_ch.overflow;
                seen.last   = out_ch.last;
                sb.check_result(seen);
            end
        end
    end

    // receiver back pressure: switch between randomly drawn patterns as each one runs out
    //   0 always ready, 1 mostly ready, 2 coin flip, 3 periodic long stalls
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(4, 40);
        end
        case (ready_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       out_ch.ready <= ($urandom_range(0, 1) != 0);
            default: out_ch.ready <= ((ready_left % 9) < 4);
        endcase
        ready_left--;
    end

    // appends one byte to the line being built
    function automatic void add_byte(input logic [7:0] b);
        line_q = {line_q, b};
    endfunction

    // one item, with a random gap at the start of each burst; returns at the falling edge
    // after the item was taken
    task automatic send_item(input logic req, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts follow the previous one back to back
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.in_byte  <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // sends the bytes in line_q and closes the line
    task automatic send_line(input logic [7:0] eol_byte);
        foreach (line_q[i])
            send_item(REQ_BYTE, line_q[i]);
        send_item(REQ_EOL, eol_byte);
        line_q.delete();
    endtask

    // hold the sender off until every owed result is out, then let a held flush settle
    task automatic drain(input int settle);
        in_ch.valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
        burst_left = 0;
    endtask

    function automatic logic [7:0] trim_blank_char();
        case ($urandom_range(0, 3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0D;
            default: return 8'h0A;
        endcase
    endfunction

    // any byte that is not c whitespace, mostly printable
    function automatic logic [7:0] token_char();
        logic [7:0] b;
        do
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(33, 126));
        while (tokenizer_scoreboard::is_sep(b));
        return b;
    endfunction

    initial
    begin
        int         line_no;
        int         pick;
        int         kw;
        int         len;
        logic [7:0] c;

        sb = new();
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_BYTE;
        in_ch.in_byte  = 8'h00;
        out_ch.ready   = 1'b0;
        burst_left     = 0;
        items_sent     = 0;
        ready_left     = 0;
        ready_mode     = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed lines
        // empty line, end-of-line byte all ones
        send_line(8'hFF);
        // all-blank line
        line_q = '{8'h20, 8'h09};
        send_line(8'h00);
        // mixed-case keyword with a tab tail that gets trimmed at line end
        line_q = '{"p", "I", "n", "G", 8'h09};
        send_line(8'h5A);
        // name starting with a carriage return is unknown
        line_q = '{8'h0D, "c"};
        send_line(8'hA5);
        // extreme byte values as a token, then a trailing parameter with a held run
        line_q = '{"x", 8'h20, 8'h00, 8'hFF, 8'h20, ":", 8'h20, 8'h09, "z"};
        send_line(8'h3C);

        // sender pause until the block has caught up
        drain(40);

        // random lines; two stress lines are forced early so they always appear
        items_sent = 0;
        line_no = 0;
        while (items_sent < 330)
        begin
            pick = (line_no == 2) ? 4 : (line_no == 5) ? 5 : $urandom_range(0, 19);
            if (pick < 4)
            begin
                // noise, biased toward the bytes the parser reacts to
                repeat ($urandom_range(0, 14))
                begin
                    if ($urandom_range(0, 2) == 0)
                        add_byte(($urandom_range(0, 1) == 0) ? 8'h3A : trim_blank_char());
                    else
                        add_byte(8'($urandom_range(0, 255)));
                end
            end
            else if (pick == 4)
            begin
                // more parameters than the block keeps: overflow and discard
                line_q = '{"J", "o", "i", "n"};
                repeat ($urandom_range(15, 18))
                begin
                    add_byte(8'h20);
                    add_byte(token_char());
                end
                add_byte(8'h20);
                add_byte(":");
                add_byte("x");
            end
            else if (pick == 5)
            begin
                // blank run around the hold depth inside a trailing parameter
                line_q = '{"P", "R", "I", "V", "M", "S", "G", 8'h20, "#", 8'h20, ":", "h"};
                repeat ($urandom_range(30, 36))
                    add_byte(trim_blank_char());
                add_byte("!");
            end
            else
            begin
                // well-formed command line with random content
                repeat ($urandom_range(0, 2))
                    add_byte(($urandom_range(0, 1) == 0) ? 8'h20 : 8'h09);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    kw = $urandom_range(0, NKEYS - 1);
                    for (int i = 0; i < sb.kw_names[kw].len(); i++)
                    begin
                        c = sb.kw_names[kw][i];
                        if ($urandom_range(0, 1) == 0)
                            c = c + 8'd32;
                        add_byte(c);
                    end
                end
                else if (pick < 9)
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 18)
                                                      : $urandom_range(1, 7);
                    repeat (len)
                        add_byte(token_char());
                end
                else
                begin
                    add_byte(($urandom_range(0, 1) == 0) ? 8'h0D : 8'h0A);
                    add_byte(token_char());
                end
                // blank tail on the name, sometimes followed by more name bytes
                if ($urandom_range(0, 5) == 0)
                begin
                    add_byte(($urandom_range(0, 1) == 0) ? 8'h09 : 8'h0A);
                    if ($urandom_range(0, 1) == 0)
                        add_byte(token_char());
                end
                repeat ($urandom_range(0, 4))
                begin
                    add_byte(8'h20);
                    if ($urandom_range(0, 1) == 0)
                        add_byte(($urandom_range(0, 2) == 0)
                                 ? 8'($urandom_range(11, 12)) : trim_blank_char());
                    repeat ($urandom_range(1, 6))
                        add_byte(token_char());
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    add_byte(8'h20);
                    add_byte(":");
                    repeat ($urandom_range(0, 4))
                    begin
                        repeat ($urandom_range(0, 3))
                            add_byte(trim_blank_char());
                        repeat ($urandom_range(1, 4))
                            add_byte(token_char());
                    end
                end
                repeat ($urandom_range(0, 2))
                    add_byte(trim_blank_char());
            end
            send_line(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
                drain(2);
            line_no++;
        end

        // wait out the last results and any late flush
        drain(40);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
